@@ rtl/core/spp_pkg.sv @@
package spp_pkg;

    localparam int PATTERN_BLOCKS = 64;
    localparam int OFS_W          = $clog2(PATTERN_BLOCKS);
    localparam int BLOCK_W        = 58;
    localparam int PATTERN_W      = 64;
    localparam int COUNT_W        = 6;

    typedef enum logic [1:0] {
        KIND_PREFETCH = 2'd0,
        KIND_ERASED   = 2'd1,
        KIND_LIMIT    = 2'd2,
        KIND_NO_ENTRY = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MISS,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic  load;
        logic  advance;
        logic  issue;
        logic  emit_status;
        kind_t status_kind;
    } cmd_t;

    typedef struct packed {
        logic found;
        logic hit;
        logic limit;
        logic at_end;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/core/spp_ctrl.sv @@
module spp_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  spp_pkg::sts_t sts,
    output spp_pkg::cmd_t cmd
);
    import spp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.found ? S_SCAN : S_MISS;
                end
            end
            S_MISS:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (sts.hit && sts.out_free && sts.limit)
                begin
                    state_next = S_IDLE;
                end
                else if ((!sts.hit || sts.out_free) && sts.at_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready            = 1'b0;
        cmd.load            = 1'b0;
        cmd.advance         = 1'b0;
        cmd.issue           = 1'b0;
        cmd.emit_status     = 1'b0;
        cmd.status_kind     = KIND_ERASED;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_MISS:
            begin
                cmd.emit_status = sts.out_free;
                cmd.status_kind = KIND_NO_ENTRY;
            end
            S_SCAN:
            begin
                if (!sts.hit)
                begin
                    cmd.advance = 1'b1;
                end
                else if (sts.out_free)
                begin
                    if (sts.limit)
                    begin
                        cmd.emit_status = 1'b1;
                        cmd.status_kind = KIND_LIMIT;
                    end
                    else
                    begin
                        cmd.issue   = 1'b1;
                        cmd.advance = 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                cmd.emit_status = sts.out_free;
                cmd.status_kind = KIND_ERASED;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.issue && cmd.emit_status))
        else $error("issue and status in one cycle");

    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_status |=> state_reg == S_IDLE)
        else $error("status did not end the run");

endmodule

@@ rtl/core/spp_dp.sv @@
module spp_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [spp_pkg::BLOCK_W-1:0]       block_number,
    input  logic [spp_pkg::PATTERN_W-1:0]     stored_pattern,
    input  logic                              entry_found,
    input  logic [spp_pkg::COUNT_W-1:0]       free_slots,
    input  spp_pkg::cmd_t                     cmd,
    output spp_pkg::sts_t                     sts,
    output logic                              out_valid,
    input  logic                              out_ready,
    output spp_pkg::kind_t                    kind,
    output logic [spp_pkg::BLOCK_W-1:0]       prefetch_block,
    output logic [spp_pkg::PATTERN_W-1:0]     remaining_pattern,
    output logic [spp_pkg::COUNT_W-1:0]       issued_count,
    output logic                              last
);
    import spp_pkg::*;

    localparam logic [OFS_W:0] PB_LIMIT = (OFS_W+1)'(PATTERN_BLOCKS);
    localparam logic [OFS_W-1:0] D_LAST = OFS_W'(PATTERN_BLOCKS - 1);

    logic [PATTERN_BLOCKS-1:0] pat_reg, pat_next;
    logic [BLOCK_W-1:0]        base_reg, base_next;
    logic [OFS_W-1:0]          ofs_reg, ofs_next;
    logic [OFS_W-1:0]          dist_reg, dist_next;
    logic                      side_reg, side_next;
    logic [COUNT_W-1:0]        slots_reg, slots_next;
    logic [COUNT_W-1:0]        issued_reg, issued_next;

    logic                      out_valid_reg, out_valid_next;
    kind_t                     kind_reg, kind_next;
    logic [BLOCK_W-1:0]        pblk_reg, pblk_next;
    logic [PATTERN_W-1:0]      rem_reg, rem_next;
    logic [COUNT_W-1:0]        cnt_reg, cnt_next;
    logic                      last_reg, last_next;

    logic [OFS_W:0]            up_sum;
    logic                      cand_ok;
    logic [OFS_W-1:0]          cand;
    logic [OFS_W-1:0]          ld_ofs;
    logic [PATTERN_BLOCKS-1:0] ld_pat;

    assign up_sum  = {1'b0, ofs_reg} + {1'b0, dist_reg};
    assign cand_ok = side_reg ? (dist_reg <= ofs_reg) : (up_sum < PB_LIMIT);
    assign cand    = side_reg ? (ofs_reg - dist_reg) : up_sum[OFS_W-1:0];

    assign ld_ofs = OFS_W'(block_number % PATTERN_BLOCKS);
    assign ld_pat = stored_pattern[PATTERN_BLOCKS-1:0]
                    & ~(PATTERN_BLOCKS'(1) << ld_ofs);

    always_comb
    begin
        sts.found    = entry_found;
        sts.hit      = cand_ok && pat_reg[cand];
        sts.limit    = issued_reg >= slots_reg;
        sts.at_end   = (dist_reg == D_LAST) && side_reg;
        sts.out_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        pat_next    = pat_reg;
        base_next   = base_reg;
        ofs_next    = ofs_reg;
        dist_next   = dist_reg;
        side_next   = side_reg;
        slots_next  = slots_reg;
        issued_next = issued_reg;
        if (cmd.load)
        begin
            pat_next    = ld_pat;
            base_next   = BLOCK_W'((block_number / PATTERN_BLOCKS) * PATTERN_BLOCKS);
            ofs_next    = ld_ofs;
            dist_next   = OFS_W'(1);
            side_next   = 1'b0;
            slots_next  = free_slots;
            issued_next = '0;
        end
        else
        begin
            if (cmd.issue)
            begin
                pat_next    = pat_reg & ~(PATTERN_BLOCKS'(1) << cand);
                issued_next = issued_reg + COUNT_W'(1);
            end
            if (cmd.advance)
            begin
                side_next = !side_reg;
                if (side_reg)
                begin
                    dist_next = dist_reg + OFS_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        pblk_next      = pblk_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        if (cmd.issue)
        begin
            out_valid_next = 1'b1;
            kind_next      = KIND_PREFETCH;
            pblk_next      = base_reg + BLOCK_W'(cand);
            rem_next       = '0;
            cnt_next       = issued_reg + COUNT_W'(1);
            last_next      = 1'b0;
        end
        else if (cmd.emit_status)
        begin
            out_valid_next = 1'b1;
            kind_next      = cmd.status_kind;
            pblk_next      = '0;
            if (cmd.status_kind == KIND_NO_ENTRY)
            begin
                rem_next = '0;
                cnt_next = '0;
            end
            else
            begin
                rem_next = PATTERN_W'(pat_reg);
                cnt_next = issued_reg;
            end
            last_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            issued_reg    <= '0;
            slots_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            issued_reg    <= issued_next;
            slots_reg     <= slots_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg  <= pat_next;
        base_reg <= base_next;
        ofs_reg  <= ofs_next;
        dist_reg <= dist_next;
        side_reg <= side_next;
        kind_reg <= kind_next;
        pblk_reg <= pblk_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        last_reg <= last_next;
    end

    assign out_valid         = out_valid_reg;
    assign kind              = kind_reg;
    assign prefetch_block    = pblk_reg;
    assign remaining_pattern = rem_reg;
    assign issued_count      = cnt_reg;
    assign last              = last_reg;

    a_issue_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> sts.hit && !sts.limit)
        else $error("prefetch issued without a pending block or slot");

    a_free_out: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue || cmd.emit_status) |-> sts.out_free)
        else $error("result register overwritten");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issued_reg <= slots_reg)
        else $error("issued count passed free slots");

    a_issue_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |=> issued_reg == $past(issued_reg) + COUNT_W'(1))
        else $error("issued count did not advance");

endmodule

@@ rtl/core/spatial_pattern_prefetch_issue_core.sv @@
// channel   direction  handshake             payload
// request   in         in_valid / in_ready   block_number, stored_pattern, entry_found, free_slots
// result    out        out_valid / out_ready kind, prefetch_block, remaining_pattern,
//                                            issued_count, last
//
// One request at a time: accept, then check each candidate offset (up to 126) in turn,
// then give the status result; a scan that meets a pending block with no free slot left
// ends with a limit status. A request with no entry gives only a no-entry status.
// A pending block waits while the result register is full and not taken.
// Reset clears the sequencer and the result valid; no clearing pass.
module spatial_pattern_prefetch_issue_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [spp_pkg::BLOCK_W-1:0]   block_number,
    input  logic [spp_pkg::PATTERN_W-1:0] stored_pattern,
    input  logic                          entry_found,
    input  logic [spp_pkg::COUNT_W-1:0]   free_slots,
    output logic                          out_valid,
    input  logic                          out_ready,
    output spp_pkg::kind_t                kind,
    output logic [spp_pkg::BLOCK_W-1:0]   prefetch_block,
    output logic [spp_pkg::PATTERN_W-1:0] remaining_pattern,
    output logic [spp_pkg::COUNT_W-1:0]   issued_count,
    output logic                          last
);
    import spp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    spp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spp_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .block_number      (block_number),
        .stored_pattern    (stored_pattern),
        .entry_found       (entry_found),
        .free_slots        (free_slots),
        .cmd               (cmd),
        .sts               (sts),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .kind              (kind),
        .prefetch_block    (prefetch_block),
        .remaining_pattern (remaining_pattern),
        .issued_count      (issued_count),
        .last              (last)
    );

endmodule
